// ----- src/psfra_pkg.sv -----
package psfra_pkg;

  localparam int ADDR_W  = 32;
  localparam int LINE_W  = 32;
  localparam int CFG_W   = 9;
  localparam int CNT_W   = 9;
  localparam int TOTAL_W = 16;
  localparam int IDX_W   = 2;

  localparam logic [CFG_W-1:0]   THRESHOLD_RST = 9'd5;
  localparam logic [CFG_W-1:0]   WINDOW_RST    = 9'd100;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX     = 16'hFFFF;
  localparam logic [CNT_W-1:0]   CNT_MAX       = 9'h1FF;

  typedef enum logic [IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WINDOW    = 2'd1
  } cfg_idx_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic accept;   // request taken this cycle
    logic scan;     // walk history ring and source table
    logic resolve;  // pick slot, allocate new source
    logic update;   // finish record, load result
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [ADDR_W-1:0] addr;
  } hist_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [LINE_W-1:0]  start_line;
    logic               alerted;
  } rec_t;

endpackage

// ----- src/psfra_ctrl.sv -----
module psfra_ctrl
  import psfra_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_UPDATE
  } state_t;

  state_t state;

  assign s_tready    = (state == ST_IDLE);
  assign cmd.accept  = (state == ST_IDLE) && s_tvalid;
  assign cmd.scan    = (state == ST_SCAN);
  assign cmd.resolve = (state == ST_RESOLVE);
  assign cmd.update  = (state == ST_UPDATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:    if (s_tvalid) state <= ST_SCAN;
        ST_SCAN:    if (stat.scan_done) state <= ST_RESOLVE;
        ST_RESOLVE: state <= ST_UPDATE;
        ST_UPDATE:  if (stat.out_free) state <= ST_IDLE;
        default:    state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/psfra_dp.sv -----
module psfra_dp
  import psfra_pkg::*;
#(
  parameter int HISTORY_DEPTH  = 256,
  parameter int SOURCE_ENTRIES = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic [ADDR_W-1:0]         in_addr,
  input  logic [LINE_W-1:0]         in_line,
  input  logic                      cfg_valid,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_alert,
  output logic [CNT_W-1:0]          out_recent,
  output logic [TOTAL_W-1:0]        out_total,
  output logic [LINE_W-1:0]         out_first,
  output logic                      out_flagged,
  output logic                      out_full
);

  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int TAW = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
  localparam int TCW = $clog2(SOURCE_ENTRIES + 1);
  localparam int WW  = (HCW > CFG_W) ? HCW : CFG_W;

  // config registers
  logic [CFG_W-1:0] threshold;
  logic [CFG_W-1:0] window;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RST;
      window    <= WINDOW_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold <= cfg_data;
        CFG_WINDOW:    window    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // current request
  logic [ADDR_W-1:0] cur_addr;
  logic [LINE_W-1:0] cur_line;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_addr <= in_addr;
      cur_line <= in_line;
    end
  end

  // history ring
  hist_t           hist_mem [HISTORY_DEPTH];
  hist_t           hist_rd;
  logic [HAW-1:0]  wptr;
  logic [HCW-1:0]  fill;
  logic [HCW-1:0]  hidx;
  logic            hrd_v;
  logic [HCW-1:0]  count;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hist_mem[wptr] <= '{line: in_line, addr: in_addr};
    end
    hist_rd <= hist_mem[hidx[HAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      fill <= '0;
    end else if (cmd.accept) begin
      wptr <= (wptr == HAW'(HISTORY_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (fill != HCW'(HISTORY_DEPTH)) fill <= fill + 1'b1;
    end
  end

  // effective window never exceeds ring depth
  logic [WW-1:0]     win_w;
  logic [WW-1:0]     win_eff;
  logic [LINE_W-1:0] line_gap;
  logic              hit;

  assign win_w    = WW'(window);
  assign win_eff  = (win_w > WW'(HISTORY_DEPTH)) ? WW'(HISTORY_DEPTH) : win_w;
  assign line_gap = cur_line - hist_rd.line;
  assign hit      = hrd_v && (hist_rd.addr == cur_addr) && (line_gap < LINE_W'(win_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      hidx  <= '0;
      hrd_v <= 1'b0;
      count <= '0;
    end else if (cmd.accept) begin
      hidx  <= '0;
      hrd_v <= 1'b0;
      count <= '0;
    end else if (cmd.scan) begin
      hrd_v <= (hidx != fill);
      if (hidx != fill) hidx <= hidx + 1'b1;
      if (hit) count <= count + 1'b1;
    end
  end

  // source table: address store scanned, record store read at slot
  logic [ADDR_W-1:0] tab_addr_mem [SOURCE_ENTRIES];
  rec_t              rec_mem      [SOURCE_ENTRIES];
  logic [ADDR_W-1:0] tab_rd;
  rec_t              rec_rd;
  logic [TCW-1:0]    used;
  logic [TCW-1:0]    tidx;
  logic [TAW-1:0]    tidx_q;
  logic              trd_v;
  logic              found;
  logic [TAW-1:0]    slot;
  logic              is_new;
  logic              full;
  logic              rec_we;
  rec_t              rec_wd;

  always_ff @(posedge clk) begin
    if (cmd.resolve && !found && (used != TCW'(SOURCE_ENTRIES))) begin
      tab_addr_mem[used[TAW-1:0]] <= cur_addr;
    end
    tab_rd <= tab_addr_mem[tidx[TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[slot] <= rec_wd;
    end
    rec_rd <= rec_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= '0;
      tidx   <= '0;
      tidx_q <= '0;
      trd_v  <= 1'b0;
      found  <= 1'b0;
      slot   <= '0;
      is_new <= 1'b0;
      full   <= 1'b0;
    end else if (cmd.accept) begin
      tidx   <= '0;
      trd_v  <= 1'b0;
      found  <= 1'b0;
      is_new <= 1'b0;
      full   <= 1'b0;
    end else if (cmd.scan) begin
      trd_v  <= (tidx != used);
      tidx_q <= tidx[TAW-1:0];
      if (tidx != used) tidx <= tidx + 1'b1;
      if (trd_v && (tab_rd == cur_addr)) begin
        found <= 1'b1;
        slot  <= tidx_q;
      end
    end else if (cmd.resolve && !found) begin
      if (used != TCW'(SOURCE_ENTRIES)) begin
        is_new <= 1'b1;
        slot   <= used[TAW-1:0];
        used   <= used + 1'b1;
      end else begin
        full <= 1'b1;
      end
    end
  end

  assign stat.scan_done = (hidx == fill) && !hrd_v && (tidx == used) && !trd_v;
  assign stat.out_free  = !out_valid || out_ready;

  // record update
  rec_t             rec_in;
  logic [TOTAL_W-1:0] total_next;
  logic [WW-1:0]    count_w;
  logic             reach;
  logic             alert_next;
  logic [CNT_W-1:0] recent_sat;
  logic             load;

  assign rec_in     = is_new ? rec_t'{total: '0, start_line: cur_line, alerted: 1'b0} : rec_rd;
  assign total_next = (rec_in.total == TOTAL_MAX) ? rec_in.total : rec_in.total + 1'b1;
  assign count_w    = WW'(count);
  assign reach      = (count_w >= WW'(threshold));
  assign alert_next = !rec_in.alerted && reach;
  assign recent_sat = (count_w > WW'(CNT_MAX)) ? CNT_MAX : count_w[CNT_W-1:0];
  assign load       = cmd.update && stat.out_free;
  assign rec_we     = load && !full;
  assign rec_wd     = '{total: total_next, start_line: rec_in.start_line,
                        alerted: rec_in.alerted || alert_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_recent  <= recent_sat;
      out_full    <= full;
      out_alert   <= full ? 1'b0 : alert_next;
      out_total   <= full ? '0 : total_next;
      out_first   <= full ? '0 : rec_in.start_line;
      out_flagged <= full ? 1'b0 : rec_in.alerted;
    end
  end

endmodule

// ----- src/per_source_failure_rate_alarm_core.sv -----
// Per-source failure rate alarm.
// Input stream s_*: one failed-attempt request per beat, tdata = {line, addr}.
// Output stream m_*: exactly one result per request, in order.
// Config channel cfg_*: index 0 = alert threshold, 1 = window in lines;
//   always ready, write only while the block is idle.
// Each request is written into a ring of the last HISTORY_DEPTH requests, then
//   the ring (current fill) and the source table (entries in use) are scanned
//   side by side, one memory read per cycle each.
// From accept to m_tvalid a request passes the scan, resolve and update states;
//   the scan lasts until both the ring fill and the table entries are walked. One
//   request is in flight at a time; s_tready is high only in idle, so a new request
//   is taken only after the previous one has left the update state.
// The result sits in an output register; the next request is accepted while it
//   waits. If the receiver still stalls when the next result is ready, the
//   engine holds until m_tready frees the register.
// Reset (rst, synchronous): ring and table empty, threshold 5, window 100,
//   no result pending. Memories are not cleared; only filled entries are read.
module per_source_failure_rate_alarm_core
  import psfra_pkg::*;
#(
  parameter int HISTORY_DEPTH  = 256,
  parameter int SOURCE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,   // [31:0] source_addr, [63:32] attempt line
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,   // [0] alert, [9:1] recent_count,
                                       // [25:10] source_total,
                                       // [57:26] source_first_line,
                                       // [58] already_flagged, [59] table_full,
                                       // [63:60] zero
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  logic               alert;
  logic [CNT_W-1:0]   recent;
  logic [TOTAL_W-1:0] total;
  logic [LINE_W-1:0]  first;
  logic               flagged;
  logic               full;

  // config registers live in the datapath and take a write every cycle
  assign cfg_ready = 1'b1;

  psfra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psfra_dp #(
    .HISTORY_DEPTH  (HISTORY_DEPTH),
    .SOURCE_ENTRIES (SOURCE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_addr     (s_tdata[31:0]),
    .in_line     (s_tdata[63:32]),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_alert   (alert),
    .out_recent  (recent),
    .out_total   (total),
    .out_first   (first),
    .out_flagged (flagged),
    .out_full    (full)
  );

  // pack result fields, lowest field first
  assign m_tdata = {4'b0000, full, flagged, first, total, recent, alert};

endmodule
